@@ rtl/cns_pkg.sv @@
// Shared types, constants and fixed-point helpers for the Cholesky Newton step unit.
package cns_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int MINP_W = 31;

    // Divider: one quotient bit per step, two steps per stage.
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = DATA_W / DIV_STEPS;
    localparam int DIV_LAT    = DIV_STAGES + 2;

    // Square root over the widened radicand, one result bit per step.
    localparam int SQ_NUM_W  = DATA_W + FRAC_W;
    localparam int SQ_RES_W  = SQ_NUM_W / 2;
    localparam int SQ_STEPS  = 2;
    localparam int SQ_STAGES = SQ_RES_W / SQ_STEPS;
    localparam int SQ_LAT    = SQ_STAGES + 2;

    localparam int MUL_LAT = 2;

    // Positions in the context line where each phase reads its operands.
    localparam int B_SQ0  = 0;
    localparam int B_DIV0 = B_SQ0 + SQ_LAT + 1;
    localparam int B_MUL0 = B_DIV0 + DIV_LAT + 1;
    localparam int B_SQ1  = B_MUL0 + MUL_LAT + 1;
    localparam int B_DIV1 = B_SQ1 + SQ_LAT + 1;
    localparam int B_MUL1 = B_DIV1 + DIV_LAT + 1;
    localparam int B_SQ2  = B_MUL1 + MUL_LAT + 1;
    localparam int B_DIV2 = B_SQ2 + SQ_LAT + 1;
    localparam int B_DIV3 = B_DIV2 + DIV_LAT + 1;
    localparam int B_MUL2 = B_DIV3 + DIV_LAT + 1;
    localparam int B_DIV4 = B_MUL2 + MUL_LAT + 1;
    localparam int B_MUL3 = B_DIV4 + DIV_LAT + 1;
    localparam int B_DIV5 = B_MUL3 + MUL_LAT + 1;
    localparam int B_END  = B_DIV5 + DIV_LAT + 1;
    localparam int DEPTH  = B_END + 1;

    localparam int IN_TW  = ((9 * DATA_W + 7) / 8) * 8;
    localparam int OUT_TW = ((3 * DATA_W + 7) / 8) * 8;
    localparam int CMP_W  = DATA_W + 32;

    typedef logic signed [DATA_W-1:0] fx_t;

    localparam fx_t FX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam fx_t FX_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [2*DATA_W-1:0] LIM = (2*DATA_W)'(1) << (DATA_W - 1);

    typedef struct packed {
        logic                  neg;
        logic [2*DATA_W-1:0]   mag;
    } mprod_t;

    typedef struct packed {
        logic vld;
        logic fail;
        fx_t  piv;
        fx_t  h01;
        fx_t  h02;
        fx_t  h11;
        fx_t  h12;
        fx_t  h22;
        fx_t  ng0;
        fx_t  ng1;
        fx_t  ng2;
        fx_t  l0;
        fx_t  l1;
        fx_t  l2;
        fx_t  l3;
        fx_t  l4;
        fx_t  l5;
        fx_t  y0;
        fx_t  y1;
        fx_t  y2;
        fx_t  x0;
        fx_t  x1;
        fx_t  x2;
        fx_t  m2x;
        fx_t  a12;
        fx_t  b1;
        fx_t  c2;
        fx_t  r22;
        fx_t  t2;
        fx_t  u1;
        fx_t  u0;
    } ctx_t;

    function automatic logic [DATA_W-1:0] mag(input fx_t a);
        return a[DATA_W-1] ? (~a + 1'b1) : a;
    endfunction

    function automatic fx_t sat_mag(input logic neg, input logic [2*DATA_W-1:0] m);
        if (neg) begin
            if (m > LIM) return FX_MIN;
            return fx_t'(~m[DATA_W-1:0] + 1'b1);
        end
        if (m > LIM - 1'b1) return FX_MAX;
        return fx_t'(m[DATA_W-1:0]);
    endfunction

    function automatic fx_t sat_sub(input fx_t a, input fx_t b);
        logic [DATA_W:0] d;
        d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (d[DATA_W] != d[DATA_W-1]) return d[DATA_W] ? FX_MIN : FX_MAX;
        return fx_t'(d[DATA_W-1:0]);
    endfunction

    function automatic mprod_t mul_full(input fx_t a, input fx_t b);
        mprod_t p;
        p.neg = a[DATA_W-1] ^ b[DATA_W-1];
        p.mag = {{DATA_W{1'b0}}, mag(a)} * {{DATA_W{1'b0}}, mag(b)};
        return p;
    endfunction

    function automatic fx_t mul_fin(input mprod_t p);
        return sat_mag(p.neg, p.mag >> FRAC_W);
    endfunction

    // Pivot is rejected at or below the threshold.
    function automatic logic piv_bad(input fx_t piv, input logic [MINP_W-1:0] mp);
        return $signed({{(CMP_W-DATA_W){piv[DATA_W-1]}}, piv})
            <= $signed({{(CMP_W-MINP_W){1'b0}}, mp});
    endfunction

endpackage

@@ rtl/cns_div.sv @@
// Pipelined saturating fixed-point divider, two quotient bits per stage.
module cns_div (
    input  logic          aclk,
    input  logic          ce,
    input  cns_pkg::fx_t  num,
    input  cns_pkg::fx_t  den,
    output cns_pkg::fx_t  quo
);

    localparam int W  = cns_pkg::DATA_W;
    localparam int F  = cns_pkg::FRAC_W;
    localparam int NS = cns_pkg::DIV_STAGES;

    typedef struct packed {
        logic [W:0]   r;
        logic [W-1:0] q;
        logic [W-1:0] nb;
        logic [W-1:0] d;
        logic         neg;
        logic         bz;
        logic         aneg;
        logic         ovf;
    } dstage_t;

    dstage_t      st_reg  [NS+1];
    dstage_t      st_next [NS+1];
    dstage_t      cur;
    dstage_t      last;
    logic [W-1:0] an;
    logic [W:0]   t;
    cns_pkg::fx_t quo_reg;
    cns_pkg::fx_t quo_next;

    always_comb begin
        an = cns_pkg::mag(num);
        st_next[0].d    = cns_pkg::mag(den);
        st_next[0].r    = (W+1)'(an >> (W - F));
        st_next[0].nb   = an << F;
        st_next[0].q    = '0;
        st_next[0].ovf  = ((W+1)'(an >> (W - F))) >= {1'b0, cns_pkg::mag(den)};
        st_next[0].bz   = (den == '0);
        st_next[0].neg  = num[W-1] ^ den[W-1];
        st_next[0].aneg = num[W-1];
        t   = '0;
        cur = '0;
        for (int k = 0; k < NS; k++) begin
            cur = st_reg[k];
            for (int s = 0; s < cns_pkg::DIV_STEPS; s++) begin
                t = {cur.r[W-1:0], cur.nb[W-1]};
                if (t >= {1'b0, cur.d}) begin
                    cur.r = t - {1'b0, cur.d};
                    cur.q = {cur.q[W-2:0], 1'b1};
                end else begin
                    cur.r = t;
                    cur.q = {cur.q[W-2:0], 1'b0};
                end
                cur.nb = cur.nb << 1;
            end
            st_next[k+1] = cur;
        end
    end

    always_comb begin
        last = st_reg[NS];
        if (last.bz) begin
            quo_next = last.aneg ? cns_pkg::FX_MIN : cns_pkg::FX_MAX;
        end else if (last.ovf) begin
            quo_next = last.neg ? cns_pkg::FX_MIN : cns_pkg::FX_MAX;
        end else begin
            quo_next = cns_pkg::sat_mag(last.neg, {{W{1'b0}}, last.q});
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k <= NS; k++) begin
                st_reg[k] <= st_next[k];
            end
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

@@ rtl/cns_sqrt.sv @@
// Pipelined fixed-point square root, two result bits per stage.
module cns_sqrt (
    input  logic          aclk,
    input  logic          ce,
    input  cns_pkg::fx_t  rad,
    output cns_pkg::fx_t  root
);

    localparam int W  = cns_pkg::DATA_W;
    localparam int F  = cns_pkg::FRAC_W;
    localparam int NB = cns_pkg::SQ_NUM_W;
    localparam int RB = cns_pkg::SQ_RES_W;
    localparam int NS = cns_pkg::SQ_STAGES;

    typedef struct packed {
        logic [RB+1:0] rem;
        logic [RB-1:0] res;
        logic [NB-1:0] nm;
    } sstage_t;

    sstage_t       st_reg  [NS+1];
    sstage_t       st_next [NS+1];
    sstage_t       cur;
    logic [RB+1:0] t;
    logic [RB+1:0] tr;
    logic          pos;
    cns_pkg::fx_t  root_reg;

    always_comb begin
        // Non-positive radicand gives zero.
        pos = !rad[W-1] && (rad != '0);
        st_next[0].rem = '0;
        st_next[0].res = '0;
        st_next[0].nm  = pos ? (NB'(unsigned'(rad)) << F) : '0;
        t   = '0;
        tr  = '0;
        cur = '0;
        for (int k = 0; k < NS; k++) begin
            cur = st_reg[k];
            for (int s = 0; s < cns_pkg::SQ_STEPS; s++) begin
                t  = {cur.rem[RB-1:0], cur.nm[NB-1 -: 2]};
                tr = {cur.res, 2'b01};
                if (t >= tr) begin
                    cur.rem = t - tr;
                    cur.res = {cur.res[RB-2:0], 1'b1};
                end else begin
                    cur.rem = t;
                    cur.res = {cur.res[RB-2:0], 1'b0};
                end
                cur.nm = cur.nm << 2;
            end
            st_next[k+1] = cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k <= NS; k++) begin
                st_reg[k] <= st_next[k];
            end
            root_reg <= cns_pkg::sat_mag(1'b0, (2*W)'(st_reg[NS].res));
        end
    end

    assign root = root_reg;

endmodule

@@ rtl/cholesky_newton_step_3x3_unit.sv @@
// Top level: pipelined 3x3 Cholesky factor and solve giving one Newton step per item.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------------
//  s_       | in        | s_tvalid/s_tready  | s_tdata: h_00 h_01 h_02 h_11 h_12 h_22
//           |           |                    |          grad_0 grad_1 grad_2
//  m_       | out       | m_tvalid/m_tready  | m_tdata: step_0 step_1 step_2; m_tuser: solved
//  cfg_     | in        | cfg_wr_en          | cfg_wr_data: min_pivot
//
// One item enters per cycle while s_tready is high.
// The line is a chain of three root units, six dependent divider passes and four
// multiply passes, each followed by one context register.
// Reset clears min_pivot and every valid bit of the line.
// While a result waits on m_tready, the whole line holds and s_tready is low.
module cholesky_newton_step_3x3_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // h_00, h_01, h_02, h_11, h_12, h_22, grad_0, grad_1, grad_2 from bit 0 up
    input  logic [cns_pkg::IN_TW-1:0]    s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // step_0, step_1, step_2 from bit 0 up
    output logic [cns_pkg::OUT_TW-1:0]   m_tdata,
    // solved
    output logic                         m_tuser,
    input  logic                         cfg_wr_en,
    input  logic [cns_pkg::MINP_W-1:0]   cfg_wr_data
);

    localparam int W     = cns_pkg::DATA_W;
    localparam int DEPTH = cns_pkg::DEPTH;

    localparam int DV_L1 = 0;
    localparam int DV_L2 = 1;
    localparam int DV_Y0 = 2;
    localparam int DV_L4 = 3;
    localparam int DV_Y1 = 4;
    localparam int DV_Y2 = 5;
    localparam int DV_X2 = 6;
    localparam int DV_X1 = 7;
    localparam int DV_X0 = 8;
    localparam int NDIV  = 9;

    localparam int SQ_L0 = 0;
    localparam int SQ_L3 = 1;
    localparam int SQ_L5 = 2;
    localparam int NSQ   = 3;

    localparam int MU_11 = 0;
    localparam int MU_12 = 1;
    localparam int MU_22 = 2;
    localparam int MU_1Y = 3;
    localparam int MU_2Y = 4;
    localparam int MU_44 = 5;
    localparam int MU_4Y = 6;
    localparam int MU_4X = 7;
    localparam int MU_2X = 8;
    localparam int MU_1X = 9;
    localparam int NMUL  = 10;

    logic [cns_pkg::MINP_W-1:0] min_pivot_reg;
    cns_pkg::ctx_t              line_reg  [DEPTH];
    cns_pkg::ctx_t              line_next [DEPTH];
    logic                       adv;

    cns_pkg::fx_t   div_a [NDIV];
    cns_pkg::fx_t   div_b [NDIV];
    cns_pkg::fx_t   div_q [NDIV];
    cns_pkg::fx_t   sq_in [NSQ];
    cns_pkg::fx_t   sq_out[NSQ];
    cns_pkg::fx_t   mul_a [NMUL];
    cns_pkg::fx_t   mul_b [NMUL];
    cns_pkg::mprod_t prod_reg [NMUL];
    cns_pkg::fx_t   mres_reg [NMUL];
    cns_pkg::fx_t   piv1;
    cns_pkg::fx_t   piv2;

    // Advance the whole line unless a finished result is held.
    assign adv      = !line_reg[DEPTH-1].vld || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_pivot_reg <= '0;
        end else if (cfg_wr_en) begin
            min_pivot_reg <= cfg_wr_data;
        end
    end

    // Unit operands
    always_comb begin
        sq_in[SQ_L0] = line_reg[cns_pkg::B_SQ0].piv;
        sq_in[SQ_L3] = line_reg[cns_pkg::B_SQ1].piv;
        sq_in[SQ_L5] = line_reg[cns_pkg::B_SQ2].piv;

        div_a[DV_L1] = line_reg[cns_pkg::B_DIV0].h01;
        div_b[DV_L1] = line_reg[cns_pkg::B_DIV0].l0;
        div_a[DV_L2] = line_reg[cns_pkg::B_DIV0].h02;
        div_b[DV_L2] = line_reg[cns_pkg::B_DIV0].l0;
        div_a[DV_Y0] = line_reg[cns_pkg::B_DIV0].ng0;
        div_b[DV_Y0] = line_reg[cns_pkg::B_DIV0].l0;
        div_a[DV_L4] = line_reg[cns_pkg::B_DIV1].a12;
        div_b[DV_L4] = line_reg[cns_pkg::B_DIV1].l3;
        div_a[DV_Y1] = line_reg[cns_pkg::B_DIV1].b1;
        div_b[DV_Y1] = line_reg[cns_pkg::B_DIV1].l3;
        div_a[DV_Y2] = line_reg[cns_pkg::B_DIV2].t2;
        div_b[DV_Y2] = line_reg[cns_pkg::B_DIV2].l5;
        div_a[DV_X2] = line_reg[cns_pkg::B_DIV3].y2;
        div_b[DV_X2] = line_reg[cns_pkg::B_DIV3].l5;
        div_a[DV_X1] = line_reg[cns_pkg::B_DIV4].u1;
        div_b[DV_X1] = line_reg[cns_pkg::B_DIV4].l3;
        div_a[DV_X0] = line_reg[cns_pkg::B_DIV5].u0;
        div_b[DV_X0] = line_reg[cns_pkg::B_DIV5].l0;

        mul_a[MU_11] = line_reg[cns_pkg::B_MUL0].l1;
        mul_b[MU_11] = line_reg[cns_pkg::B_MUL0].l1;
        mul_a[MU_12] = line_reg[cns_pkg::B_MUL0].l1;
        mul_b[MU_12] = line_reg[cns_pkg::B_MUL0].l2;
        mul_a[MU_22] = line_reg[cns_pkg::B_MUL0].l2;
        mul_b[MU_22] = line_reg[cns_pkg::B_MUL0].l2;
        mul_a[MU_1Y] = line_reg[cns_pkg::B_MUL0].l1;
        mul_b[MU_1Y] = line_reg[cns_pkg::B_MUL0].y0;
        mul_a[MU_2Y] = line_reg[cns_pkg::B_MUL0].l2;
        mul_b[MU_2Y] = line_reg[cns_pkg::B_MUL0].y0;
        mul_a[MU_44] = line_reg[cns_pkg::B_MUL1].l4;
        mul_b[MU_44] = line_reg[cns_pkg::B_MUL1].l4;
        mul_a[MU_4Y] = line_reg[cns_pkg::B_MUL1].l4;
        mul_b[MU_4Y] = line_reg[cns_pkg::B_MUL1].y1;
        mul_a[MU_4X] = line_reg[cns_pkg::B_MUL2].l4;
        mul_b[MU_4X] = line_reg[cns_pkg::B_MUL2].x2;
        mul_a[MU_2X] = line_reg[cns_pkg::B_MUL2].l2;
        mul_b[MU_2X] = line_reg[cns_pkg::B_MUL2].x2;
        mul_a[MU_1X] = line_reg[cns_pkg::B_MUL3].l1;
        mul_b[MU_1X] = line_reg[cns_pkg::B_MUL3].x1;
    end

    for (genvar i = 0; i < NDIV; i++) begin : g_div
        cns_div u_div (
            .aclk (aclk),
            .ce   (adv),
            .num  (div_a[i]),
            .den  (div_b[i]),
            .quo  (div_q[i])
        );
    end

    for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
        cns_sqrt u_sqrt (
            .aclk (aclk),
            .ce   (adv),
            .rad  (sq_in[i]),
            .root (sq_out[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NMUL; i++) begin
                prod_reg[i] <= cns_pkg::mul_full(mul_a[i], mul_b[i]);
                mres_reg[i] <= cns_pkg::mul_fin(prod_reg[i]);
            end
        end
    end

    // Context line: shift by default, merge unit results at phase boundaries.
    always_comb begin
        line_next[0]      = '0;
        line_next[0].vld  = s_tvalid;
        line_next[0].piv  = s_tdata[0*W +: W];
        line_next[0].fail = cns_pkg::piv_bad(s_tdata[0*W +: W], min_pivot_reg);
        line_next[0].h01  = s_tdata[1*W +: W];
        line_next[0].h02  = s_tdata[2*W +: W];
        line_next[0].h11  = s_tdata[3*W +: W];
        line_next[0].h12  = s_tdata[4*W +: W];
        line_next[0].h22  = s_tdata[5*W +: W];
        line_next[0].ng0  = cns_pkg::sat_sub('0, s_tdata[6*W +: W]);
        line_next[0].ng1  = cns_pkg::sat_sub('0, s_tdata[7*W +: W]);
        line_next[0].ng2  = cns_pkg::sat_sub('0, s_tdata[8*W +: W]);
        for (int k = 1; k < DEPTH; k++) begin
            line_next[k] = line_reg[k-1];
        end

        line_next[cns_pkg::B_DIV0].l0 = sq_out[SQ_L0];

        line_next[cns_pkg::B_MUL0].l1 = div_q[DV_L1];
        line_next[cns_pkg::B_MUL0].l2 = div_q[DV_L2];
        line_next[cns_pkg::B_MUL0].y0 = div_q[DV_Y0];

        piv1 = cns_pkg::sat_sub(line_reg[cns_pkg::B_SQ1-1].h11, mres_reg[MU_11]);
        line_next[cns_pkg::B_SQ1].piv  = piv1;
        line_next[cns_pkg::B_SQ1].fail = line_reg[cns_pkg::B_SQ1-1].fail
                                       || cns_pkg::piv_bad(piv1, min_pivot_reg);
        line_next[cns_pkg::B_SQ1].a12  =
            cns_pkg::sat_sub(line_reg[cns_pkg::B_SQ1-1].h12, mres_reg[MU_12]);
        line_next[cns_pkg::B_SQ1].r22  =
            cns_pkg::sat_sub(line_reg[cns_pkg::B_SQ1-1].h22, mres_reg[MU_22]);
        line_next[cns_pkg::B_SQ1].b1   =
            cns_pkg::sat_sub(line_reg[cns_pkg::B_SQ1-1].ng1, mres_reg[MU_1Y]);
        line_next[cns_pkg::B_SQ1].c2   =
            cns_pkg::sat_sub(line_reg[cns_pkg::B_SQ1-1].ng2, mres_reg[MU_2Y]);

        line_next[cns_pkg::B_DIV1].l3 = sq_out[SQ_L3];

        line_next[cns_pkg::B_MUL1].l4 = div_q[DV_L4];
        line_next[cns_pkg::B_MUL1].y1 = div_q[DV_Y1];

        piv2 = cns_pkg::sat_sub(line_reg[cns_pkg::B_SQ2-1].r22, mres_reg[MU_44]);
        line_next[cns_pkg::B_SQ2].piv  = piv2;
        line_next[cns_pkg::B_SQ2].fail = line_reg[cns_pkg::B_SQ2-1].fail
                                       || cns_pkg::piv_bad(piv2, min_pivot_reg);
        line_next[cns_pkg::B_SQ2].t2   =
            cns_pkg::sat_sub(line_reg[cns_pkg::B_SQ2-1].c2, mres_reg[MU_4Y]);

        line_next[cns_pkg::B_DIV2].l5 = sq_out[SQ_L5];

        line_next[cns_pkg::B_DIV3].y2 = div_q[DV_Y2];

        line_next[cns_pkg::B_MUL2].x2 = div_q[DV_X2];

        line_next[cns_pkg::B_DIV4].u1  =
            cns_pkg::sat_sub(line_reg[cns_pkg::B_DIV4-1].y1, mres_reg[MU_4X]);
        line_next[cns_pkg::B_DIV4].m2x = mres_reg[MU_2X];

        line_next[cns_pkg::B_MUL3].x1 = div_q[DV_X1];

        line_next[cns_pkg::B_DIV5].u0 = cns_pkg::sat_sub(
            cns_pkg::sat_sub(line_reg[cns_pkg::B_DIV5-1].y0, mres_reg[MU_1X]),
            line_reg[cns_pkg::B_DIV5-1].m2x);

        // Drop the step on a rejected pivot.
        if (line_reg[cns_pkg::B_END-1].fail) begin
            line_next[cns_pkg::B_END].x0 = '0;
            line_next[cns_pkg::B_END].x1 = '0;
            line_next[cns_pkg::B_END].x2 = '0;
        end else begin
            line_next[cns_pkg::B_END].x0 = div_q[DV_X0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DEPTH; k++) begin
                line_reg[k].vld <= 1'b0;
            end
        end else if (adv) begin
            for (int k = 0; k < DEPTH; k++) begin
                line_reg[k] <= line_next[k];
            end
        end
    end

    assign m_tvalid = line_reg[DEPTH-1].vld;
    assign m_tuser  = !line_reg[DEPTH-1].fail;
    assign m_tdata  = cns_pkg::OUT_TW'({line_reg[DEPTH-1].x2,
                                        line_reg[DEPTH-1].x1,
                                        line_reg[DEPTH-1].x0});

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("failed solve carries a nonzero step");

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result is held");

    a_root_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (line_reg[cns_pkg::B_DIV5].vld && !line_reg[cns_pkg::B_DIV5].fail)
            |-> ($signed(line_reg[cns_pkg::B_DIV5].l0) > 0))
        else $error("accepted pivot with non-positive root");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && line_reg[DEPTH-2].vld) |=> m_tvalid)
        else $error("item lost at the output stage");

endmodule

@@ bench/cholesky_newton_step_3x3_unit_test.sv @@
// Testbench for the pipelined 3x3 Cholesky Newton step unit.
`timescale 1ns / 1ps

module cholesky_newton_step_3x3_unit_test;

    typedef cns_pkg::fx_t fx_t;
    typedef logic signed [63:0] w64_t;

    localparam int  IN_TW  = cns_pkg::IN_TW;
    localparam int  OUT_TW = cns_pkg::OUT_TW;
    localparam int  MINP_W = cns_pkg::MINP_W;
    localparam int  FRAC_W = cns_pkg::FRAC_W;
    localparam fx_t FX_MAX = cns_pkg::FX_MAX;
    localparam fx_t FX_MIN = cns_pkg::FX_MIN;

    typedef struct packed {
        fx_t  s0;
        fx_t  s1;
        fx_t  s2;
        logic ok;
    } step_t;

    localparam int STALL_LIMIT = 20000;
    localparam int PIPE_WAIT   = 400;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_TW-1:0]     s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_TW-1:0]    m_tdata;
    logic                 m_tuser;
    logic                 cfg_wr_en = 1'b0;
    logic [MINP_W-1:0]    cfg_wr_data = '0;

    logic [MINP_W-1:0]    min_pivot_q = '0;
    step_t                pending_steps[$];
    int                   errors = 0;
    int                   sent = 0;
    int                   got = 0;
    int                   solved_cnt = 0;
    int                   idle_cycles = 0;
    int                   src_idle_pct = 0;
    int                   dst_stall_pct = 0;

    always #5 aclk = ~aclk;

    cholesky_newton_step_3x3_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    // ---- fixed-point arithmetic on wide intermediates ----
    function automatic w64_t clamp(input logic signed [129:0] v);
        if (v > 130'sd2147483647) return 64'sd2147483647;
        if (v < -130'sd2147483648) return -64'sd2147483648;
        return w64_t'(v);
    endfunction

    function automatic w64_t q_sub(input w64_t a, input w64_t b);
        return clamp(130'(a) - 130'(b));
    endfunction

    function automatic w64_t q_mul(input w64_t a, input w64_t b);
        logic [127:0] m;
        logic [63:0]  ma, mb;
        ma = a < 0 ? 64'(-a) : 64'(a);
        mb = b < 0 ? 64'(-b) : 64'(b);
        m = (128'(ma) * 128'(mb)) >> FRAC_W;
        return ((a < 0) != (b < 0)) ? clamp(-$signed({2'b0, m})) : clamp($signed({2'b0, m}));
    endfunction

    function automatic w64_t q_div(input w64_t a, input w64_t b);
        logic [127:0] m;
        logic [63:0]  ma, mb;
        if (b == 0) return a < 0 ? -64'sd2147483648 : 64'sd2147483647;
        ma = a < 0 ? 64'(-a) : 64'(a);
        mb = b < 0 ? 64'(-b) : 64'(b);
        m = (128'(ma) << FRAC_W) / 128'(mb);
        return ((a < 0) != (b < 0)) ? clamp(-$signed({2'b0, m})) : clamp($signed({2'b0, m}));
    endfunction

    function automatic w64_t q_sqrt(input w64_t p);
        logic [127:0] n, r, b;
        if (p <= 0) return 0;
        n = 128'(p) << FRAC_W;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            b = r | (128'd1 << i);
            if (b * b <= n) r = b;
        end
        return clamp($signed({2'b0, r}));
    endfunction

    // Solve H x = -g by Cholesky; zero step when a pivot is rejected.
    function automatic step_t newton_step(input logic [IN_TW-1:0] d);
        w64_t h[6], g[3], l0, l1, l2, l3, l4, l5, pv, y0, y1, y2, x0, x1, x2, mp;
        step_t r;
        for (int i = 0; i < 6; i++) h[i] = w64_t'($signed(d[i*32 +: 32]));
        for (int i = 0; i < 3; i++) g[i] = w64_t'($signed(d[(6+i)*32 +: 32]));
        mp = w64_t'({33'b0, min_pivot_q});
        r = '0;
        pv = h[0];
        if (pv <= mp) return r;
        l0 = q_sqrt(pv);
        l1 = q_div(h[1], l0);
        l2 = q_div(h[2], l0);
        pv = q_sub(h[3], q_mul(l1, l1));
        if (pv <= mp) return r;
        l3 = q_sqrt(pv);
        l4 = q_div(q_sub(h[4], q_mul(l1, l2)), l3);
        pv = q_sub(q_sub(h[5], q_mul(l2, l2)), q_mul(l4, l4));
        if (pv <= mp) return r;
        l5 = q_sqrt(pv);
        y0 = q_div(q_sub(0, g[0]), l0);
        y1 = q_div(q_sub(q_sub(0, g[1]), q_mul(l1, y0)), l3);
        y2 = q_div(q_sub(q_sub(q_sub(0, g[2]), q_mul(l2, y0)), q_mul(l4, y1)), l5);
        x2 = q_div(y2, l5);
        x1 = q_div(q_sub(y1, q_mul(l4, x2)), l3);
        x0 = q_div(q_sub(q_sub(y0, q_mul(l1, x1)), q_mul(l2, x2)), l0);
        r.s0 = fx_t'(x0);
        r.s1 = fx_t'(x1);
        r.s2 = fx_t'(x2);
        r.ok = 1'b1;
        return r;
    endfunction

    // ---- result checker and watchdog ----
    always @(posedge aclk) begin
        step_t e;
        if (aresetn && m_tvalid && m_tready) begin
            got <= got + 1;
            if (pending_steps.size() == 0) begin
                $display("%0t: unexpected result step=%h solved=%b", $time, m_tdata, m_tuser);
                errors <= errors + 1;
            end else begin
                e = pending_steps.pop_front();
                if (m_tuser) solved_cnt <= solved_cnt + 1;
                if (m_tdata[31:0] !== e.s0 || m_tdata[63:32] !== e.s1 ||
                    m_tdata[95:64] !== e.s2 || m_tuser !== e.ok) begin
                    $display("%0t: mismatch expected %h %h %h solved=%b actual %h %h %h solved=%b",
                             $time, e.s0, e.s1, e.s2, e.ok,
                             m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser);
                    errors <= errors + 1;
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_steps.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver stalls at the configured rate.
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= dst_stall_pct);

    // ---- stimulus helpers ----
    // Valid stays high after the item until the next item replaces it or an idle cycle or drain drops it.
    task automatic send_item(input logic [IN_TW-1:0] d);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_steps.push_back(newton_step(d));
        sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_steps.size() != 0) @(negedge aclk);
        repeat (PIPE_WAIT) @(negedge aclk);
    endtask

    task automatic write_min_pivot(input logic [MINP_W-1:0] v);
        drain();
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        min_pivot_q = v;
    endtask

    function automatic logic [IN_TW-1:0] pack(input fx_t a0, a1, a2, a3, a4, a5,
                                              b0, b1, b2);
        return {b2, b1, b0, a5, a4, a3, a2, a1, a0};
    endfunction

    function automatic fx_t rnd_val();
        case ($urandom_range(5))
            0: return fx_t'($urandom);
            1: return fx_t'($urandom_range(4));
            2: return $urandom_range(1) ? FX_MAX : FX_MIN;
            default: return fx_t'($signed($urandom_range(32'h00200000)) - 32'sh00100000);
        endcase
    endfunction

    // Well-conditioned symmetric positive definite matrix with random content.
    function automatic logic [IN_TW-1:0] spd_item();
        fx_t d0, d1, d2;
        d0 = fx_t'($urandom_range(32'h00400000, 32'h00010000));
        d1 = fx_t'($urandom_range(32'h00400000, 32'h00010000));
        d2 = fx_t'($urandom_range(32'h00400000, 32'h00010000));
        return pack(d0, fx_t'($signed($urandom_range(32'h8000)) - 32'sh4000),
                    fx_t'($signed($urandom_range(32'h8000)) - 32'sh4000), d1,
                    fx_t'($signed($urandom_range(32'h8000)) - 32'sh4000), d2,
                    rnd_val(), rnd_val(), rnd_val());
    endfunction

    // ---- tests ----
    task automatic test_directed();
        fx_t one;
        one = fx_t'(32'h00010000);
        send_item(pack(one, 0, 0, one, 0, one, one, -one, 0));
        send_item(pack(FX_MAX, FX_MAX, FX_MIN, FX_MAX, FX_MIN, FX_MAX, FX_MAX, FX_MIN, FX_MAX));
        send_item(pack(FX_MIN, 0, 0, one, 0, one, one, one, one));
        send_item(pack(0, 0, 0, one, 0, one, one, one, one));
        send_item(pack(1, 0, 0, 1, 0, 1, FX_MAX, FX_MIN, FX_MAX));
        send_item(pack(one, one, 0, one, 0, one, one, one, one));
        send_item(pack(one, 0, one, one, 0, one, one, one, one));
        send_item(pack(one, 0, 0, one, one, one, one, one, one));
        send_item(pack(1, FX_MAX, FX_MIN, FX_MAX, FX_MAX, FX_MAX, FX_MIN, FX_MIN, FX_MIN));
        send_item(pack(FX_MAX, 1, 1, FX_MAX, 1, FX_MAX, -1, -1, -1));
        send_item(pack(-1, -1, -1, -1, -1, -1, -1, -1, -1));
        send_item(pack(fx_t'(32'h4), 0, 0, fx_t'(32'h4), 0, fx_t'(32'h4), one, one, one));
        write_min_pivot(31'h7FFFFFFF);
        send_item(pack(FX_MAX, 0, 0, FX_MAX, 0, FX_MAX, one, one, one));
        write_min_pivot(31'h00010000);
        send_item(pack(one, 0, 0, one, 0, one, one, one, one));
        send_item(pack(one + 1, 0, 0, one + 1, 0, one + 1, one, one, one));
        send_item(pack(one + 1, 0, 0, one, 0, one + 1, one, one, one));
        send_item(pack(one + 1, 0, 0, one + 1, 0, one, one, one, one));
    endtask

    task automatic test_random(input int n, input int idle, input int stall);
        src_idle_pct  = idle;
        dst_stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 80) send_item(spd_item());
            else send_item(pack(rnd_val(), rnd_val(), rnd_val(), rnd_val(), rnd_val(),
                                rnd_val(), rnd_val(), rnd_val(), rnd_val()));
            // Hold off once until the line is empty.
            if (i == n / 2 && idle == 0) begin
                s_tvalid <= 1'b0;
                while (pending_steps.size() != 0) @(negedge aclk);
            end
        end
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        write_min_pivot(31'h0);
        test_random(450, 0, 0);
        write_min_pivot(31'($urandom_range(32'h00020000)));
        test_random(450, 66, 0);
        write_min_pivot(31'h00000100);
        test_random(450, 0, 66);
        write_min_pivot(31'h0);
        test_random(450, 30, 30);
        dst_stall_pct = 0;
        drain();
        $display("Sent %0d items, received %0d steps (%0d solved) over four pivot settings",
                 sent, got, solved_cnt);
        $display("and four idle/stall mixes.");
        if (errors == 0 && pending_steps.size() == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule
